// ===== hdl/i2cmbt_pkg.sv =====
// Shared types and constants for the I2C byte-transaction master.
// Used by i2cmbt_sequencer and i2c_master_byte_transactions_core; no dependencies.
package i2cmbt_pkg;

   // Command codes carried by an input item.
   localparam logic [1:0] ACT_TICK     = 2'd0;
   localparam logic [1:0] ACT_WRITE    = 2'd1;
   localparam logic [1:0] ACT_READ_ONE = 2'd2;
   localparam logic [1:0] ACT_READ_TWO = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_ACK_POLL_LIMIT = 1'b1;

   // Reset value of the ACK poll limit.
   localparam logic [7:0] ACK_POLL_LIMIT_RESET = 8'd100;

   // Sequencer phases.
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START,
      PH_WB_PRE,
      PH_WB_BIT,
      PH_RS_HIGH,
      PH_RS_POLL,
      PH_RS_LOW,
      PH_RB_PRE,
      PH_RB_BIT,
      PH_MACK,
      PH_STOP
   } phase_type;

   // Configuration values seen by the sequencer.
   typedef struct packed {
      logic [6:0] device_address;
      logic [7:0] ack_poll_limit;
   } cfg_type;

   // Result of one tick.
   typedef struct packed {
      logic        scl_level;
      logic        sda_level;
      logic        busy_res;
      logic        done_res;
      logic        success;
      logic [15:0] read_value;
   } result_type;

endpackage

// ===== hdl/i2c_master_byte_transactions_core.sv =====
// Top level of the I2C byte-transaction master: configuration registers,
// input handshake and result register. Depends on i2cmbt_pkg and i2cmbt_sequencer.

// Each input item is one bus timing tick and produces exactly one result item,
// presented on the rsp_ channel the cycle after the item is accepted. The block
// takes one item per clock; the only thing that slows it is the single result
// register, which must be emptied (or emptied in the same cycle) before the next
// item is taken. A command given while a transaction runs is ignored. Results
// carry the SCL and SDA levels for that tick; read_value and success are only
// meaningful on the tick with done_res set. Configuration is written through csr_write_en,
// csr_index and csr_wdata; the user must do so while no transaction is in progress; the block does not enforce it.
module i2c_master_byte_transactions_core (
   input  logic        clock,
   input  logic        reset,
   // Configuration port
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata,
   // Input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_write_value,
   input  logic        req_sda_in,
   // Result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic        rsp_success,
   output logic [15:0] rsp_read_value
);

   i2cmbt_pkg::cfg_type    cfg_ff;
   i2cmbt_pkg::result_type result;
   i2cmbt_pkg::result_type rsp_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= '0;
         cfg_ff.ack_poll_limit <= i2cmbt_pkg::ACK_POLL_LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            i2cmbt_pkg::CSR_DEVICE_ADDRESS: cfg_ff.device_address <= csr_wdata[6:0];
            i2cmbt_pkg::CSR_ACK_POLL_LIMIT: cfg_ff.ack_poll_limit <= csr_wdata;
            default: ;
         endcase
      end
   end

   // An item is taken whenever the result register is free or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   i2cmbt_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .cfg         (cfg_ff),
      .action      (req_action),
      .write_value (req_write_value),
      .sda_in      (req_sda_in),
      .result      (result)
   );

   // Result register.
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_level  = rsp_data_ff.scl_level;
   assign rsp_sda_level  = rsp_data_ff.sda_level;
   assign rsp_busy_res   = rsp_data_ff.busy_res;
   assign rsp_done_res   = rsp_data_ff.done_res;
   assign rsp_success    = rsp_data_ff.success;
   assign rsp_read_value = rsp_data_ff.read_value;

   // The completing tick always belongs to a running transaction.
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.done_res |-> rsp_data_ff.busy_res)
      else $error("done reported outside a transaction");

   // Status and read data stay clear except on the completing tick.
   a_status_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.done_res |->
         !rsp_data_ff.success && (rsp_data_ff.read_value == 16'd0))
      else $error("success or read data reported without done");

   // An idle tick leaves both bus lines released.
   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.busy_res |->
         rsp_data_ff.scl_level && rsp_data_ff.sda_level)
      else $error("bus driven while idle");

endmodule

// ===== hdl/i2cmbt_sequencer.sv =====
// Tick sequencer of the I2C byte-transaction master: transaction state and
// the bus levels and status of the current tick. Depends on i2cmbt_pkg.
module i2cmbt_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  i2cmbt_pkg::cfg_type    cfg,
   input  logic [1:0]             action,
   input  logic [7:0]             write_value,
   input  logic                   sda_in,
   output i2cmbt_pkg::result_type result
);

   i2cmbt_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  operation_ff, operation_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [1:0]  sub_tick_ff, sub_tick_in;
   logic [7:0]  poll_count_ff, poll_count_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [15:0] received_word_ff, received_word_in;
   logic        address_acked_ff, address_acked_in;
   logic        byte_index_ff, byte_index_in;
   logic        two_bytes;

   // State registers advance once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= i2cmbt_pkg::PH_IDLE;
         operation_ff     <= i2cmbt_pkg::ACT_TICK;
         bit_count_ff     <= '0;
         sub_tick_ff      <= '0;
         poll_count_ff    <= '0;
         shift_byte_ff    <= '0;
         received_word_ff <= '0;
         address_acked_ff <= 1'b0;
         byte_index_ff    <= 1'b0;
      end else if (step) begin
         phase_ff         <= phase_in;
         operation_ff     <= operation_in;
         bit_count_ff     <= bit_count_in;
         sub_tick_ff      <= sub_tick_in;
         poll_count_ff    <= poll_count_in;
         shift_byte_ff    <= shift_byte_in;
         received_word_ff <= received_word_in;
         address_acked_ff <= address_acked_in;
         byte_index_ff    <= byte_index_in;
      end
   end

   assign two_bytes = (operation_ff == i2cmbt_pkg::ACT_READ_TWO);

   // Next state and tick outputs. A command taken in idle starts the first
   // start-condition tick in the same item.
   always_comb begin
      phase_in         = phase_ff;
      operation_in     = operation_ff;
      bit_count_in     = bit_count_ff;
      sub_tick_in      = sub_tick_ff;
      poll_count_in    = poll_count_ff;
      shift_byte_in    = shift_byte_ff;
      received_word_in = received_word_ff;
      address_acked_in = address_acked_ff;
      byte_index_in    = byte_index_ff;

      result            = '0;
      result.scl_level  = 1'b1;
      result.sda_level  = 1'b1;
      result.busy_res   = 1'b1;

      // Launch of a new transaction.
      if (phase_ff == i2cmbt_pkg::PH_IDLE) begin
         if (action != i2cmbt_pkg::ACT_TICK) begin
            operation_in     = action;
            received_word_in = (action == i2cmbt_pkg::ACT_WRITE) ?
                               {8'd0, write_value} : 16'd0;
            shift_byte_in    = {cfg.device_address, action != i2cmbt_pkg::ACT_WRITE};
            address_acked_in = 1'b0;
            byte_index_in    = 1'b0;
            phase_in         = i2cmbt_pkg::PH_START;
            sub_tick_in      = '0;
            bit_count_in     = '0;
            poll_count_in    = '0;
         end else begin
            result.busy_res = 1'b0;
         end
      end

      unique case (phase_in)
         i2cmbt_pkg::PH_IDLE: begin
            result.scl_level = 1'b1;
            result.sda_level = 1'b1;
         end
         i2cmbt_pkg::PH_START: begin
            result.scl_level = (sub_tick_in != 2'd3);
            result.sda_level = (sub_tick_in < 2'd2);
            if (sub_tick_in == 2'd3) begin
               phase_in      = i2cmbt_pkg::PH_WB_PRE;
               sub_tick_in   = '0;
               bit_count_in  = '0;
               poll_count_in = '0;
            end else begin
               sub_tick_in = sub_tick_in + 2'd1;
            end
         end
         i2cmbt_pkg::PH_WB_PRE: begin
            // SDA stays low after start, or released after the address ACK.
            result.scl_level = 1'b0;
            result.sda_level = byte_index_in;
            phase_in         = i2cmbt_pkg::PH_WB_BIT;
            sub_tick_in      = '0;
            bit_count_in     = '0;
            poll_count_in    = '0;
         end
         i2cmbt_pkg::PH_WB_BIT: begin
            result.scl_level = (sub_tick_in == 2'd1) || (sub_tick_in == 2'd2);
            result.sda_level = shift_byte_in[7];
            if (sub_tick_in == 2'd3) begin
               shift_byte_in = {shift_byte_in[6:0], 1'b0};
               sub_tick_in   = '0;
               bit_count_in  = bit_count_in + 4'd1;
               if (bit_count_in >= 4'd8) begin
                  phase_in      = i2cmbt_pkg::PH_RS_HIGH;
                  bit_count_in  = '0;
                  poll_count_in = '0;
               end
            end else begin
               sub_tick_in = sub_tick_in + 2'd1;
            end
         end
         i2cmbt_pkg::PH_RS_HIGH: begin
            phase_in      = (cfg.ack_poll_limit == 8'd0) ?
                            i2cmbt_pkg::PH_RS_LOW : i2cmbt_pkg::PH_RS_POLL;
            sub_tick_in   = '0;
            bit_count_in  = '0;
            poll_count_in = '0;
         end
         i2cmbt_pkg::PH_RS_POLL: begin
            // Poll for ACK until the device pulls SDA low or the limit runs out.
            if (!sda_in) begin
               if (!byte_index_in) begin
                  address_acked_in = 1'b1;
               end
               phase_in      = i2cmbt_pkg::PH_RS_LOW;
               sub_tick_in   = '0;
               bit_count_in  = '0;
               poll_count_in = '0;
            end else begin
               poll_count_in = poll_count_in + 8'd1;
               if (poll_count_in >= cfg.ack_poll_limit) begin
                  phase_in      = i2cmbt_pkg::PH_RS_LOW;
                  sub_tick_in   = '0;
                  bit_count_in  = '0;
                  poll_count_in = '0;
               end
            end
         end
         i2cmbt_pkg::PH_RS_LOW: begin
            result.scl_level = 1'b0;
            if (!byte_index_in && address_acked_in) begin
               if (operation_in == i2cmbt_pkg::ACT_WRITE) begin
                  byte_index_in = 1'b1;
                  shift_byte_in = received_word_in[7:0];
                  phase_in      = i2cmbt_pkg::PH_WB_PRE;
               end else begin
                  phase_in = i2cmbt_pkg::PH_RB_PRE;
               end
            end else begin
               phase_in = i2cmbt_pkg::PH_STOP;
            end
            sub_tick_in   = '0;
            bit_count_in  = '0;
            poll_count_in = '0;
         end
         i2cmbt_pkg::PH_RB_PRE: begin
            result.scl_level = 1'b0;
            phase_in         = i2cmbt_pkg::PH_RB_BIT;
            sub_tick_in      = '0;
            bit_count_in     = '0;
            poll_count_in    = '0;
         end
         i2cmbt_pkg::PH_RB_BIT: begin
            // The data bit is sampled on the second high tick.
            result.scl_level = (sub_tick_in < 2'd2);
            if (sub_tick_in == 2'd1) begin
               received_word_in = {received_word_in[14:0], sda_in};
            end
            if (sub_tick_in == 2'd2) begin
               sub_tick_in  = '0;
               bit_count_in = bit_count_in + 4'd1;
               if (bit_count_in >= 4'd8) begin
                  phase_in      = i2cmbt_pkg::PH_MACK;
                  bit_count_in  = '0;
                  poll_count_in = '0;
               end
            end else begin
               sub_tick_in = sub_tick_in + 2'd1;
            end
         end
         i2cmbt_pkg::PH_MACK: begin
            // ACK after the first byte of a two-byte read, NACK otherwise.
            result.scl_level = (sub_tick_in == 2'd2);
            result.sda_level = (sub_tick_in == 2'd0) || !(two_bytes && !byte_index_in);
            if (sub_tick_in == 2'd3) begin
               if (two_bytes && !byte_index_in) begin
                  byte_index_in = 1'b1;
                  phase_in      = i2cmbt_pkg::PH_RB_PRE;
               end else begin
                  phase_in = i2cmbt_pkg::PH_STOP;
               end
               sub_tick_in   = '0;
               bit_count_in  = '0;
               poll_count_in = '0;
            end else begin
               sub_tick_in = sub_tick_in + 2'd1;
            end
         end
         i2cmbt_pkg::PH_STOP: begin
            result.scl_level = (sub_tick_in != 2'd0);
            result.sda_level = (sub_tick_in == 2'd2);
            if (sub_tick_in == 2'd2) begin
               result.done_res   = 1'b1;
               result.success    = address_acked_in;
               result.read_value = (operation_in == i2cmbt_pkg::ACT_WRITE) ?
                                   16'd0 : received_word_in;
               phase_in      = i2cmbt_pkg::PH_IDLE;
               sub_tick_in   = '0;
               bit_count_in  = '0;
               poll_count_in = '0;
            end else begin
               sub_tick_in = sub_tick_in + 2'd1;
            end
         end
         default: begin
            phase_in        = i2cmbt_pkg::PH_IDLE;
            sub_tick_in     = '0;
            bit_count_in    = '0;
            poll_count_in   = '0;
            result.busy_res = 1'b0;
         end
      endcase
   end

endmodule

// ===== sim/tb_i2c_master_byte_transactions_core.sv =====
// Self-checking testbench for i2c_master_byte_transactions_core: it sends timing ticks
// with a responding device, predicts every result item and compares it field by field.
// Depends on i2cmbt_pkg and the RTL of the core; it reads no files.
module tb_i2c_master_byte_transactions_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1400;
   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_PRINTED = 40;

   // Block inputs, all known from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic        csr_index = i2cmbt_pkg::CSR_DEVICE_ADDRESS;
   logic [7:0]  csr_wdata = 8'h00;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = i2cmbt_pkg::ACT_TICK;
   logic [7:0]  req_write_value = 8'h00;
   logic        req_sda_in = 1'b1;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_scl_level;
   logic        rsp_sda_level;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic        rsp_success;
   logic [15:0] rsp_read_value;

   // Predicted sequencer state and configuration.
   i2cmbt_pkg::phase_type seq_phase = i2cmbt_pkg::PH_IDLE;
   logic [1:0]  seq_operation = i2cmbt_pkg::ACT_TICK;
   logic [3:0]  seq_bits = '0;
   logic [1:0]  seq_sub = '0;
   logic [7:0]  seq_polls = '0;
   logic [7:0]  seq_shift = '0;
   logic [15:0] seq_word = '0;
   logic        seq_addr_acked = 1'b0;
   logic        seq_second_byte = 1'b0;
   logic [6:0]  cfg_address = '0;
   logic [7:0]  cfg_poll_limit = i2cmbt_pkg::ACK_POLL_LIMIT_RESET;

   // Expected bus ticks, oldest first.
   i2cmbt_pkg::result_type expected_bus_ticks[$];

   // Behavior of the simulated device for the running transaction.
   bit          device_ack_address = 1'b1;
   bit          device_ack_data = 1'b1;
   int          device_ack_delay = 0;

   // Flow control and bookkeeping.
   bit          sender_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;
   int          hold_request = 0;
   int          hold_left = 0;
   int          stall_left = 0;
   int          cycle_count = 0;
   int          items_sent = 0;
   int          results_checked = 0;
   int          acked_transactions = 0;
   int          error_count = 0;
   int          transactions_by_kind[4] = '{0, 0, 0, 0};

   i2c_master_byte_transactions_core uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Cycle counter with a run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, expected_bus_ticks.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Random length of an idle stretch: mostly short, a few long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(1, 3);
      if (r < 9) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   function automatic void enter_phase(i2cmbt_pkg::phase_type p);
      seq_phase = p;
      seq_sub = '0;
      seq_bits = '0;
      seq_polls = '0;
   endfunction

   // Advances the predicted sequencer by one tick and returns the bus levels and status.
   function automatic i2cmbt_pkg::result_type predict_bus_tick(logic [1:0] action,
                                                               logic [7:0] wvalue,
                                                               logic sda);
      i2cmbt_pkg::result_type r;
      logic       two_bytes;
      r = '0;
      r.scl_level = 1'b1;
      r.sda_level = 1'b1;
      r.busy_res = 1'b1;
      two_bytes = (seq_operation == i2cmbt_pkg::ACT_READ_TWO);
      // A command starts a transaction only from idle.
      if (seq_phase == i2cmbt_pkg::PH_IDLE) begin
         if (action != i2cmbt_pkg::ACT_TICK) begin
            seq_operation = action;
            seq_word = (action == i2cmbt_pkg::ACT_WRITE) ? {8'h00, wvalue} : 16'h0000;
            seq_shift = {cfg_address, action != i2cmbt_pkg::ACT_WRITE};
            seq_addr_acked = 1'b0;
            seq_second_byte = 1'b0;
            enter_phase(i2cmbt_pkg::PH_START);
         end else begin
            r.busy_res = 1'b0;
         end
      end
      case (seq_phase)
         i2cmbt_pkg::PH_IDLE: begin
         end
         i2cmbt_pkg::PH_START: begin
            r.scl_level = (seq_sub < 2'd3);
            r.sda_level = (seq_sub < 2'd2);
            if (seq_sub == 2'd3) enter_phase(i2cmbt_pkg::PH_WB_PRE);
            else seq_sub = seq_sub + 2'd1;
         end
         i2cmbt_pkg::PH_WB_PRE: begin
            // SDA still low from the start for the address, released after an ACK.
            r.scl_level = 1'b0;
            r.sda_level = seq_second_byte;
            enter_phase(i2cmbt_pkg::PH_WB_BIT);
         end
         i2cmbt_pkg::PH_WB_BIT: begin
            r.scl_level = (seq_sub == 2'd1 || seq_sub == 2'd2);
            r.sda_level = seq_shift[7];
            if (seq_sub == 2'd3) begin
               seq_shift = {seq_shift[6:0], 1'b0};
               seq_sub = '0;
               seq_bits = seq_bits + 4'd1;
               if (seq_bits >= 4'd8) enter_phase(i2cmbt_pkg::PH_RS_HIGH);
            end else begin
               seq_sub = seq_sub + 2'd1;
            end
         end
         i2cmbt_pkg::PH_RS_HIGH: begin
            if (cfg_poll_limit == 8'd0) enter_phase(i2cmbt_pkg::PH_RS_LOW);
            else enter_phase(i2cmbt_pkg::PH_RS_POLL);
         end
         i2cmbt_pkg::PH_RS_POLL: begin
            if (!sda) begin
               if (!seq_second_byte) seq_addr_acked = 1'b1;
               enter_phase(i2cmbt_pkg::PH_RS_LOW);
            end else begin
               seq_polls = seq_polls + 8'd1;
               if (seq_polls >= cfg_poll_limit) enter_phase(i2cmbt_pkg::PH_RS_LOW);
            end
         end
         i2cmbt_pkg::PH_RS_LOW: begin
            r.scl_level = 1'b0;
            if (!seq_second_byte && seq_addr_acked) begin
               if (seq_operation == i2cmbt_pkg::ACT_WRITE) begin
                  seq_second_byte = 1'b1;
                  seq_shift = seq_word[7:0];
                  enter_phase(i2cmbt_pkg::PH_WB_PRE);
               end else begin
                  enter_phase(i2cmbt_pkg::PH_RB_PRE);
               end
            end else begin
               enter_phase(i2cmbt_pkg::PH_STOP);
            end
         end
         i2cmbt_pkg::PH_RB_PRE: begin
            r.scl_level = 1'b0;
            enter_phase(i2cmbt_pkg::PH_RB_BIT);
         end
         i2cmbt_pkg::PH_RB_BIT: begin
            r.scl_level = (seq_sub < 2'd2);
            if (seq_sub == 2'd1) seq_word = {seq_word[14:0], sda};
            if (seq_sub == 2'd2) begin
               seq_sub = '0;
               seq_bits = seq_bits + 4'd1;
               if (seq_bits >= 4'd8) enter_phase(i2cmbt_pkg::PH_MACK);
            end else begin
               seq_sub = seq_sub + 2'd1;
            end
         end
         i2cmbt_pkg::PH_MACK: begin
            // Only the first byte of a two-byte read is acknowledged.
            r.scl_level = (seq_sub == 2'd2);
            if (seq_sub == 2'd0) r.sda_level = 1'b1;
            else r.sda_level = !(two_bytes && !seq_second_byte);
            if (seq_sub == 2'd3) begin
               if (two_bytes && !seq_second_byte) begin
                  seq_second_byte = 1'b1;
                  enter_phase(i2cmbt_pkg::PH_RB_PRE);
               end else begin
                  enter_phase(i2cmbt_pkg::PH_STOP);
               end
            end else begin
               seq_sub = seq_sub + 2'd1;
            end
         end
         i2cmbt_pkg::PH_STOP: begin
            r.scl_level = (seq_sub != 2'd0);
            r.sda_level = (seq_sub == 2'd2);
            if (seq_sub == 2'd2) begin
               r.done_res = 1'b1;
               r.success = seq_addr_acked;
               r.read_value = (seq_operation == i2cmbt_pkg::ACT_WRITE) ? 16'h0000 : seq_word;
               enter_phase(i2cmbt_pkg::PH_IDLE);
            end else begin
               seq_sub = seq_sub + 2'd1;
            end
         end
         default: begin
            enter_phase(i2cmbt_pkg::PH_IDLE);
            r.busy_res = 1'b0;
         end
      endcase
      return r;
   endfunction

   // SDA level the simulated device puts on the line for the next tick.
   function automatic logic device_sda();
      bit acking;
      if (seq_phase == i2cmbt_pkg::PH_RS_POLL) begin
         acking = seq_second_byte ? device_ack_data : device_ack_address;
         return !(acking && seq_polls >= device_ack_delay);
      end
      return 1'($urandom_range(0, 1));
   endfunction

   // Offers one item and records its predicted result once it is accepted.
   task automatic send_tick(logic [1:0] action, logic [7:0] wvalue, logic sda);
      int         gap;
      i2cmbt_pkg::result_type predicted;
      gap = (sender_quiet || $urandom_range(0, 99) < 60) ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_write_value <= wvalue;
      req_sda_in <= sda;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      predicted = predict_bus_tick(action, wvalue, sda);
      expected_bus_ticks.push_back(predicted);
      items_sent++;
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   // Writes both registers once every expected result has arrived.
   task automatic configure(logic [7:0] address_byte, logic [7:0] poll_limit);
      stop_sending();
      while (expected_bus_ticks.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= i2cmbt_pkg::CSR_DEVICE_ADDRESS;
      csr_wdata <= address_byte;
      @(posedge clock);
      cfg_address = address_byte[6:0];
      csr_index <= i2cmbt_pkg::CSR_ACK_POLL_LIMIT;
      csr_wdata <= poll_limit;
      @(posedge clock);
      cfg_poll_limit = poll_limit;
      csr_write_en <= 1'b0;
   endtask

   // Runs one transaction to its done tick. With noise, commands are also given while busy,
   // always on the done tick.
   task automatic run_transaction(logic [1:0] kind, logic [7:0] data, bit ack_address,
                                  bit ack_data, int ack_delay, bit noisy);
      logic [1:0] action;
      device_ack_address = ack_address;
      device_ack_data = ack_data;
      device_ack_delay = ack_delay;
      transactions_by_kind[kind]++;
      send_tick(kind, data, 1'($urandom_range(0, 1)));
      while (seq_phase != i2cmbt_pkg::PH_IDLE) begin
         action = i2cmbt_pkg::ACT_TICK;
         if (noisy && ($urandom_range(0, 3) == 0 ||
                       (seq_phase == i2cmbt_pkg::PH_STOP && seq_sub == 2'd2)))
            action = 2'($urandom_range(i2cmbt_pkg::ACT_WRITE, i2cmbt_pkg::ACT_READ_TWO));
         send_tick(action, 8'($urandom_range(0, 255)), device_sda());
      end
   endtask

   // Idle ticks with extreme payloads start nothing.
   task automatic test_idle_ticks();
      send_tick(i2cmbt_pkg::ACT_TICK, 8'h00, 1'b0);
      send_tick(i2cmbt_pkg::ACT_TICK, 8'hFF, 1'b1);
      send_tick(i2cmbt_pkg::ACT_TICK, 8'h55, 1'b0);
      send_tick(i2cmbt_pkg::ACT_TICK, 8'hAA, 1'b1);
   endtask

   // Writes with extreme addresses and data, and one whose data byte is not acknowledged.
   task automatic test_writes();
      configure(8'hFF, 8'd100);
      run_transaction(i2cmbt_pkg::ACT_WRITE, 8'hFF, 1'b1, 1'b1, 0, 1'b0);
      configure(8'h00, 8'd8);
      run_transaction(i2cmbt_pkg::ACT_WRITE, 8'h00, 1'b1, 1'b1, 2, 1'b0);
      run_transaction(i2cmbt_pkg::ACT_WRITE, 8'hA5, 1'b1, 1'b0, 0, 1'b0);
   endtask

   // Single and double reads, including an ACK on the very last poll tick.
   task automatic test_reads();
      configure(8'h2A, 8'd20);
      run_transaction(i2cmbt_pkg::ACT_READ_ONE, 8'h00, 1'b1, 1'b1, 1, 1'b0);
      run_transaction(i2cmbt_pkg::ACT_READ_TWO, 8'hFF, 1'b1, 1'b1, 0, 1'b0);
      run_transaction(i2cmbt_pkg::ACT_READ_TWO, 8'h3C, 1'b1, 1'b1, 5, 1'b0);
      run_transaction(i2cmbt_pkg::ACT_READ_ONE, 8'h81, 1'b1, 1'b1, 19, 1'b0);
   endtask

   // Missing address ACK with the shortest, a zero and the longest poll limit.
   task automatic test_no_ack();
      configure(8'h13, 8'd1);
      run_transaction(i2cmbt_pkg::ACT_READ_ONE, 8'h00, 1'b0, 1'b0, 0, 1'b0);
      run_transaction(i2cmbt_pkg::ACT_WRITE, 8'h5A, 1'b0, 1'b1, 0, 1'b0);
      run_transaction(i2cmbt_pkg::ACT_READ_TWO, 8'h00, 1'b1, 1'b1, 1, 1'b0);
      configure(8'hEC, 8'd0);
      run_transaction(i2cmbt_pkg::ACT_READ_TWO, 8'h00, 1'b1, 1'b1, 0, 1'b0);
      run_transaction(i2cmbt_pkg::ACT_WRITE, 8'hC3, 1'b1, 1'b1, 0, 1'b0);
      configure(8'h01, 8'd255);
      run_transaction(i2cmbt_pkg::ACT_WRITE, 8'h7E, 1'b0, 1'b0, 0, 1'b0);
   endtask

   // Commands given while busy, the done tick among them, must be ignored.
   task automatic test_busy_commands();
      configure(8'h5A, 8'd10);
      run_transaction(i2cmbt_pkg::ACT_READ_TWO, 8'h00, 1'b1, 1'b1, 0, 1'b1);
      run_transaction(i2cmbt_pkg::ACT_WRITE, 8'h96, 1'b1, 1'b1, 3, 1'b1);
   endtask

   // The receiver holds off for a long stretch while ticks keep coming back to back.
   task automatic test_backpressure();
      sender_quiet = 1'b1;
      hold_request = 80;
      run_transaction(i2cmbt_pkg::ACT_READ_TWO, 8'h00, 1'b1, 1'b1, 0, 1'b0);
      hold_request = 60;
      run_transaction(i2cmbt_pkg::ACT_WRITE, 8'h69, 1'b1, 1'b1, 1, 1'b1);
      sender_quiet = 1'b0;
   endtask

   // Mostly well-formed transactions with random content, plus NACKs, timeouts and noise,
   // until the whole run has sent about the target number of items.
   task automatic test_random_traffic();
      int         count;
      int         pick;
      int         delay;
      logic [7:0] limit_value;
      count = 0;
      while (items_sent < ITEM_TARGET || count == 0) begin
         if (count % 6 == 5) begin
            pick = $urandom_range(0, 3);
            limit_value = (pick == 0) ? 8'd1 : (pick == 1) ? 8'd255 :
                          8'($urandom_range(2, 30));
            configure(8'($urandom_range(0, 255)), limit_value);
         end
         sender_quiet = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(0, 2)) send_tick(i2cmbt_pkg::ACT_TICK,
                                                 8'($urandom_range(0, 255)),
                                                 1'($urandom_range(0, 1)));
         pick = $urandom_range(0, 9);
         delay = (pick < 7) ? $urandom_range(0, 3) :
                 (pick < 9) ? $urandom_range(4, 20) : $urandom_range(0, 260);
         run_transaction(2'($urandom_range(i2cmbt_pkg::ACT_WRITE, i2cmbt_pkg::ACT_READ_TWO)),
                         8'($urandom_range(0, 255)),
                         $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 80, delay,
                         $urandom_range(0, 99) < 30);
         count++;
      end
      sender_quiet = 1'b0;
   endtask

   // Result receiver: random stalls, quiet stretches and requested long hold-offs.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (cycle_count % 500 == 0) rsp_quiet = ($urandom_range(0, 2) == 0);
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (!rsp_quiet && $urandom_range(0, 99) < 20) stall_left = idle_length();
      end
   end

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("MISMATCH cycle %0d result %0d: %s is 0x%0h, expected 0x%0h",
                  cycle_count, results_checked, what, got, want);
   endtask

   task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // Result checker: outputs are stable at the falling edge before the accepting edge.
   always @(negedge clock) begin : result_check
      i2cmbt_pkg::result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_bus_ticks.size() == 0) begin
            report_mismatch("result item with nothing expected", 16'h0, 16'h0);
         end else begin
            want = expected_bus_ticks.pop_front();
            results_checked++;
            if (want.done_res && want.success) acked_transactions++;
            check_field("scl_level", 16'(rsp_scl_level), 16'(want.scl_level));
            check_field("sda_level", 16'(rsp_sda_level), 16'(want.sda_level));
            check_field("busy_res", 16'(rsp_busy_res), 16'(want.busy_res));
            check_field("done_res", 16'(rsp_done_res), 16'(want.done_res));
            check_field("success", 16'(rsp_success), 16'(want.success));
            check_field("read_value", rsp_read_value, want.read_value);
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_idle_ticks();
      test_writes();
      test_reads();
      test_no_ack();
      test_busy_commands();
      test_backpressure();
      test_random_traffic();
      // Let every expected result come back, then allow a few quiet cycles.
      stop_sending();
      while (expected_bus_ticks.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Ran %0d writes, %0d single reads and %0d double reads, %0d of them acknowledged",
               transactions_by_kind[i2cmbt_pkg::ACT_WRITE],
               transactions_by_kind[i2cmbt_pkg::ACT_READ_ONE],
               transactions_by_kind[i2cmbt_pkg::ACT_READ_TWO], acked_transactions);
      $display("Checked %0d result items from %0d ticks in %0d cycles",
               results_checked, items_sent, cycle_count);
      if (error_count == 0 && expected_bus_ticks.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
